FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// depends on nothing; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SMA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the following cycle
`define SMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sma_pkg.sv
// shared constants for the moving average block
// no dependencies; used by the top level, the divider and the testbench
package sma_pkg;

	// window length register
	localparam int WL_W     = 7;
	localparam int WL_RESET = 5;
	localparam int WL_MAX   = (1 << WL_W) - 1;

	// status from the divider back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/core/sma_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module sma_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/sma_div.sv
// iterative radix-2 restoring divider, signed dividend by positive count
// depends on sma_pkg for the status struct; one quotient bit per cycle
module sma_div #(
	parameter int NUM_W = 54,
	parameter int DEN_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0]        divisor,
	output logic signed [NUM_W-1:0] quotient,
	output sma_pkg::div_stat_t      stat
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_FIX  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;
	logic [DEN_W:0]   rem_sub;

	// one trial subtraction per step
	always_comb begin
		rem_sh  = {rem_q, quo_q[NUM_W-1]};
		fits    = (rem_sh >= {1'b0, den_q});
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
						cnt_q   <= '0;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					state_q <= D_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// datapath: magnitude in, shift quotient bits in, sign restored at the end
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					neg_q <= dividend[NUM_W-1];
					quo_q <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
					rem_q <= '0;
					den_q <= divisor;
				end
			end
			D_RUN: begin
				quo_q <= {quo_q[NUM_W-2:0], fits};
				rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			end
			D_FIX: begin
				quotient <= neg_q ? -$signed(quo_q) : $signed(quo_q);
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != D_IDLE);
	assign stat.done = done_q;

endmodule

FILE: rtl/core/moving_average_running_sum_top.sv
// moving average over a ring of samples with an exact running sum
// one item at a time; the output register frees the input side
// async active-low reset: window 5, empty ring, zero sum, no result pending
// depends on sma_pkg, sma_ram and sma_div
module moving_average_running_sum_top #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 48
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // mean
	output logic                                   m_axis_tuser,  // window_full
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sma_pkg::WL_W-1:0]               cfg_data       // window_length
);

	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int EFF_MAX = (MAX_WINDOW < sma_pkg::WL_MAX) ? MAX_WINDOW : sma_pkg::WL_MAX;
	localparam int CW      = $clog2(EFF_MAX + 1);
	localparam int SW      = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
	localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W   = SAMPLE_WIDTH + $clog2(EFF_MAX);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_SUB   = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_START = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]                state_q;
	logic [sma_pkg::WL_W-1:0]  wl_q;
	logic [SW-1:0]             slot_q;
	logic [CW-1:0]             fill_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [SAMPLE_WIDTH-1:0]   sample_q;
	logic                      full_q;
	logic [SAMPLE_WIDTH-1:0]   res_q;
	logic                      m_valid_q;
	logic [SAMPLE_WIDTH-1:0]   m_mean_q;
	logic                      m_full_q;

	logic [CW-1:0]             len;
	logic [SW-1:0]             slot_use;
	logic [CW-1:0]             slot_inc;
	logic                      was_full;
	logic [CW-1:0]             fill_next;
	logic [SAMPLE_WIDTH-1:0]   old_sample;
	logic signed [SUM_W-1:0]   old_ext;
	logic signed [SUM_W-1:0]   new_ext;
	logic                      div_start;
	logic signed [SUM_W-1:0]   div_quot;
	sma_pkg::div_stat_t        div_stat;
	logic                      out_free;

	// effective window: zero means one, clamp to the ring size
	always_comb begin
		if (wl_q == '0) begin
			len = CW'(1);
		end else if (wl_q > sma_pkg::WL_W'(EFF_MAX)) begin
			len = CW'(EFF_MAX);
		end else begin
			len = CW'(wl_q);
		end
	end

	// ring position and fill bookkeeping
	always_comb begin
		slot_use  = (CW'(slot_q) >= len) ? '0 : slot_q;
		slot_inc  = CW'(slot_use) + 1'b1;
		was_full  = (fill_q >= len);
		fill_next = was_full ? len : fill_q + 1'b1;
		old_ext   = SUM_W'($signed(old_sample));
		new_ext   = SUM_W'($signed(sample_q));
		div_start = (state_q == ST_START);
		out_free  = !m_valid_q || m_axis_tready;
	end

	// configuration only between items, and ahead of a new sample
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready     = (state_q == ST_IDLE);

	// sample ring
	sma_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == ST_ADD),
		.waddr(AW'(slot_use)),
		.wdata(sample_q),
		.raddr(AW'(slot_use)),
		.rdata(old_sample)
	);

	// divider for sum over count
	sma_div #(
		.NUM_W(SUM_W),
		.DEN_W(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (fill_q),
		.quotient(div_quot),
		.stat    (div_stat)
	);

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wl_q      <= sma_pkg::WL_W'(sma_pkg::WL_RESET);
			slot_q    <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// output transaction flag: load at the end of an item, clear when taken
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				wl_q   <= cfg_data;
				slot_q <= '0;
				fill_q <= '0;
				sum_q  <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					if (was_full) begin
						sum_q <= sum_q - old_ext;
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q   <= sum_q + new_ext;
					fill_q  <= fill_next;
					slot_q  <= (slot_inc >= len) ? '0 : SW'(slot_inc);
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
		end
		if (state_q == ST_ADD) begin
			full_q <= (fill_next >= len);
		end
		if (state_q == ST_DIV && div_stat.done) begin
			res_q <= div_quot[SAMPLE_WIDTH-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			m_mean_q <= res_q;
			m_full_q <= full_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = TDATA_W'(m_mean_q);
	assign m_axis_tuser  = m_full_q;

endmodule

FILE: rtl/core/sma_checker.sv
// port-level checker for the moving average block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module sma_checker #(
	parameter int SAMPLE_WIDTH = 48
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tvalid,
	input logic                                   s_axis_tready,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready,
	input logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // mean
	input logic                                   m_axis_tuser,  // window_full
	input logic                                   cfg_valid,
	input logic                                   cfg_ready
);

	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	logic               out_wait;
	logic               in_take;
	logic               cfg_take;
	logic [TDATA_W:0]   out_word;

	// handshake shorthands
	assign out_wait = m_axis_tvalid && !m_axis_tready;
	assign in_take  = s_axis_tvalid && s_axis_tready;
	assign cfg_take = cfg_valid && cfg_ready;
	assign out_word = {m_axis_tuser, m_axis_tdata};

	// a pending result stays until taken
	`SMA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, m_axis_tvalid, "result dropped")

	// a stalled result keeps its payload
	`SMA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_wait, $stable(out_word), "result changed")

	// the block works on one sample at a time
	`SMA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_take, !s_axis_tready, "input overlap")

	// a fresh result only appears at the end of a sample's work
	`SMA_ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(m_axis_tvalid), !$past(s_axis_tready), "stray result")

	// a register write never shares its cycle with a sample
	`SMA_ASSERT_SAME(a_cfg_alone, clk, arst_n, cfg_take, !in_take, "write beside a sample")

endmodule

bind moving_average_running_sum_top sma_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sma_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

FILE: tb/moving_average_running_sum_top_tb.sv
// self-checking testbench for the moving average block, mean and window-full flag per sample
// depends on sma_pkg and moving_average_running_sum_top; holds its own running-sum predictor
`timescale 1ns / 1ps

// predicts the mean of the last window_length samples and keeps the results still owed
class mean_scoreboard;
	typedef struct {
		logic [47:0] mean;
		logic        full;
	} mean_result_t;

	mean_result_t  owed_means[$];
	longint        ring[64];
	int unsigned   next_slot  = 0;
	int unsigned   held_count = 0;
	longint        running_sum = 0;
	logic [6:0]    window_reg = 7'd5;
	int unsigned   errors = 0;

	// register write restarts averaging with an empty window
	function void set_window(input logic [6:0] value);
		window_reg  = value;
		next_slot   = 0;
		held_count  = 0;
		running_sum = 0;
	endfunction

	function int unsigned pending();
		return owed_means.size();
	endfunction

	// running-sum update for one accepted transaction
	function void note_sample(input logic [47:0] raw);
		int unsigned  span;
		int unsigned  slot;
		longint       widened;
		longint       quotient;
		mean_result_t res;
		span = (window_reg == 0) ? 1 : (window_reg > 64) ? 64 : window_reg;
		widened = $signed(raw);
		slot = (next_slot >= span) ? 0 : next_slot;
		if (held_count >= span) begin
			running_sum = running_sum - ring[slot] + widened;
			held_count  = span;
		end else begin
			running_sum = running_sum + widened;
			held_count  = held_count + 1;
		end
		ring[slot] = widened;
		slot = slot + 1;
		next_slot = (slot >= span) ? 0 : slot;
		// signed division truncates toward zero
		quotient = running_sum / longint'(held_count);
		res.mean = quotient[47:0];
		res.full = (held_count >= span);
		owed_means.insert(owed_means.size(), res);
	endfunction

	// compare one output transaction with the oldest owed result
	function void check_result(input logic [47:0] mean, input logic full);
		mean_result_t res;
		if (owed_means.size() == 0) begin
			$display("%0t unexpected result: mean %h window_full %b", $time, mean, full);
			errors++;
			return;
		end
		res = owed_means.pop_front();
		if (mean !== res.mean) begin
			$display("%0t mean mismatch: expected %h actual %h", $time, res.mean, mean);
			errors++;
		end
		if (full !== res.full) begin
			$display("%0t window_full mismatch: expected %b actual %b", $time, res.full, full);
			errors++;
		end
	endfunction
endclass

module moving_average_running_sum_top_tb;

	localparam int          DATA_W     = 48;
	localparam logic [47:0] SAMPLE_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] SAMPLE_MIN = 48'h8000_0000_0000;
	localparam int          RANDOM_ITEMS = 1000;
	localparam int          DRAIN_CYCLES = 150;
	localparam longint      CYCLE_LIMIT  = 1000000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [DATA_W-1:0]        s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [DATA_W-1:0]        m_axis_tdata;
	logic                     m_axis_tuser;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [sma_pkg::WL_W-1:0] cfg_data = '0;

	mean_scoreboard    sb = new;
	int                burst_left = 0;
	int                stall_left = 0;
	int                quiet_left = 0;
	longint            cycle_count = 0;
	int                random_sent = 0;

	moving_average_running_sum_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: check accepted transactions, stall in runs with calm stretches between
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		if (quiet_left > 0) begin
			quiet_left--;
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case ($urandom_range(0, 9))
				0: quiet_left = $urandom_range(100, 800);
				1, 2: stall_left = $urandom_range(1, 80);
				3, 4: stall_left = $urandom_range(1, 4);
				default: ;
			endcase
			m_axis_tready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL moving_average_running_sum_top");
			$finish;
		end
	end

	// mix of extremes, small values, whole numbers and raw random bits
	function automatic logic [47:0] random_sample();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return 48'(longint'($urandom_range(0, 2000)) - 1000);
			3: return 48'((longint'($urandom_range(0, 20000)) - 10000) <<< 16);
			default: return bits[47:0];
		endcase
	endfunction

	// window lengths: mostly small, with the extremes and the saturating range
	function automatic logic [6:0] random_window();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd127;
			2: return 7'd64;
			3: return 7'($urandom_range(65, 126));
			4, 5, 6: return 7'($urandom_range(1, 8));
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	// one input transaction, in bursts of random length with random gaps
	task automatic send_sample(input logic [47:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 70);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_sample(value);
		burst_left--;
	endtask

	// register write once every owed result has arrived
	task automatic write_window(input logic [6:0] value);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_window(value);
	endtask

	initial begin
		int         count;
		logic [6:0] wl;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of five: fill and wrap at both extremes, then around zero
		repeat (6) send_sample(SAMPLE_MAX);
		repeat (6) send_sample(SAMPLE_MIN);
		send_sample(48'd0);
		send_sample('1);
		send_sample(48'd1);
		// zero length acts as a window of one
		write_window(7'd0);
		send_sample(SAMPLE_MAX);
		send_sample('1);
		// lengths above the ring size saturate
		write_window(7'd127);
		repeat (3) send_sample(SAMPLE_MIN);
		// rewriting the same length restarts the window
		write_window(7'd2);
		send_sample(48'd7);
		send_sample(48'd3);
		write_window(7'd2);
		send_sample('1);
		send_sample(SAMPLE_MAX);

		// random phases, each with its own window length
		while (random_sent < RANDOM_ITEMS) begin
			wl = random_window();
			write_window(wl);
			count = (wl == 0) ? 1 : (wl > 64) ? 64 : wl;
			count = $urandom_range(10, 2 * count + 30);
			repeat (count) begin
				send_sample(random_sample());
				random_sent++;
			end
		end

		// drain, then allow for stray results
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS moving_average_running_sum_top");
		else
			$display("FAIL moving_average_running_sum_top");
		$finish;
	end
endmodule
